@@ hw/rtl/m4i_pkg.sv @@
// Shared constants and control types for the 4x4 matrix inverse block.
`default_nettype none
package m4i_pkg;

    // Default element format, signed Q16.16.
    localparam int ELEM_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // Rows, columns and cofactor lanes of the matrix.
    localparam int DIM = 4;

    // Sequencer states of the top level.
    typedef enum logic [4:0] {
        S_LOAD = 5'b00001,
        S_COF  = 5'b00010,
        S_DET  = 5'b00100,
        S_DIV  = 5'b01000,
        S_HOLD = 5'b10000
    } t_state;

    // Command from the sequencer to every lane.
    typedef struct packed {
        logic       start_cof;
        logic       start_div;
        logic [1:0] idx;
    } t_lane_cmd;

    // Status from a lane back to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_lane_sts;

endpackage
`default_nettype wire

@@ hw/rtl/matrix4_inverse.sv @@
// Top level of the 4x4 matrix inverse: row store, sequencer, four cofactor lanes and merge.
//
//  channel  direction  handshake                 beat
//  input    in         i_in_valid / o_in_stall   one matrix row, four signed elements
//  output   out        o_out_valid / i_out_stall one inverse row, row_last, singular
//
// Rows are taken one a cycle while o_in_stall is low; the fourth row starts the inverse.
// Cofactors: 4 passes of 9 serial multiply-accumulate steps, with hand-offs between them;
// the determinant follows in the merge stage. Each result row is then divided in the lanes
// and loaded into the output register once that register is free.
// Reset is synchronous and clears the row count and all sequencing state.
// While results are produced the first three rows of the next matrix are accepted;
// a stalled output beat holds and the dividers wait for it.
`default_nettype none
module matrix4_inverse
    import m4i_pkg::*;
#(
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic signed [ELEM_WIDTH-1:0] i_row_elem_0,
    input  wire logic signed [ELEM_WIDTH-1:0] i_row_elem_1,
    input  wire logic signed [ELEM_WIDTH-1:0] i_row_elem_2,
    input  wire logic signed [ELEM_WIDTH-1:0] i_row_elem_3,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic signed [ELEM_WIDTH-1:0] o_out_elem_0,
    output logic signed [ELEM_WIDTH-1:0] o_out_elem_1,
    output logic signed [ELEM_WIDTH-1:0] o_out_elem_2,
    output logic signed [ELEM_WIDTH-1:0] o_out_elem_3,
    output logic                         o_row_last,
    output logic                         o_singular
);

    localparam int E    = ELEM_WIDTH;
    localparam int CW   = 3 * E + 2;
    localparam int DETW = 4 * E + 2;

    t_state                          r_state;
    logic [1:0]                      r_row_cnt;
    logic [1:0]                      r_idx;
    logic                            r_go_cof;
    logic                            r_go_div;
    logic                            r_go_det;
    logic [DIM-1:0][DIM-1:0][E-1:0]  r_mat;

    t_lane_cmd               w_cmd;
    t_lane_sts               w_sts [DIM];
    logic [DIM-1:0][CW-1:0]  w_cof0;
    logic [DIM-1:0][E:0]     w_q;
    logic [DIM-1:0]          w_neg;
    logic [DIM-1:0]          w_ovf;
    logic [DIM-1:0]          w_done;
    logic [DIM-1:0][E-1:0]   w_col0;
    logic [DIM-1:0][E-1:0]   w_elem;
    logic [DETW-1:0]         w_det;
    logic                    w_det_done;
    logic                    w_in_acc;
    logic                    w_out_free;
    logic                    w_load;

    // Input beats are taken while loading, and during result output up to the third row.
    assign o_in_stall = !((r_state == S_LOAD) ||
                          (((r_state == S_DIV) || (r_state == S_HOLD)) &&
                           (r_row_cnt != 2'd3)));
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !o_out_valid || !i_out_stall;
    assign w_load     = (r_state == S_HOLD) && w_done[0] == 1'b0 && w_out_free;

    // Row store and row count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt <= 2'd0;
        end else if (w_in_acc) begin
            r_row_cnt <= r_row_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_mat[r_row_cnt] <= {i_row_elem_3, i_row_elem_2, i_row_elem_1, i_row_elem_0};
        end
    end

    // Sequencer over cofactor passes, determinant and result rows.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_idx    <= 2'd0;
            r_go_cof <= 1'b0;
            r_go_div <= 1'b0;
            r_go_det <= 1'b0;
        end else begin
            r_go_cof <= 1'b0;
            r_go_div <= 1'b0;
            r_go_det <= 1'b0;
            unique case (r_state)
                S_LOAD: begin
                    if (w_in_acc && (r_row_cnt == 2'd3)) begin
                        r_idx    <= 2'd0;
                        r_go_cof <= 1'b1;
                        r_state  <= S_COF;
                    end
                end
                S_COF: begin
                    if (w_done[0]) begin
                        if (r_idx == 2'd3) begin
                            r_go_det <= 1'b1;
                            r_state  <= S_DET;
                        end else begin
                            r_idx    <= r_idx + 2'd1;
                            r_go_cof <= 1'b1;
                        end
                    end
                end
                S_DET: begin
                    if (w_det_done) begin
                        r_idx    <= 2'd0;
                        r_go_div <= 1'b1;
                        r_state  <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_done[0]) begin
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (w_load) begin
                        if (r_idx == 2'd3) begin
                            r_state <= S_LOAD;
                        end else begin
                            r_idx    <= r_idx + 2'd1;
                            r_go_div <= 1'b1;
                            r_state  <= S_DIV;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign w_cmd.start_cof = r_go_cof;
    assign w_cmd.start_div = r_go_div;
    assign w_cmd.idx       = r_idx;

    // Lane k strikes out row k; the other three rows go in order.
    for (genvar k = 0; k < DIM; k++) begin : g_lane
        localparam int RA = (k == 0) ? 1 : 0;
        localparam int RB = (k <= 1) ? 2 : 1;
        localparam int RC = (k == 3) ? 2 : 3;

        m4i_lane #(
            .ELEM_WIDTH (ELEM_WIDTH),
            .FRAC_BITS  (FRAC_BITS)
        ) u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (w_cmd),
            .i_sign_base (1'(k % 2)),
            .i_row_a     (r_mat[RA]),
            .i_row_b     (r_mat[RB]),
            .i_row_c     (r_mat[RC]),
            .i_det       (w_det),
            .o_sts       (w_sts[k]),
            .o_cof0      (w_cof0[k]),
            .o_q         (w_q[k]),
            .o_neg       (w_neg[k]),
            .o_ovf       (w_ovf[k])
        );

        assign w_done[k] = w_sts[k].done;
        assign w_col0[k] = r_mat[k][0];
    end

    m4i_merge #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_det_start (r_go_det),
        .i_col0      (w_col0),
        .i_cof0      (w_cof0),
        .o_det_done  (w_det_done),
        .o_det       (w_det),
        .i_load      (w_load),
        .i_last      (r_idx == 2'd3),
        .i_q         (w_q),
        .i_neg       (w_neg),
        .i_ovf       (w_ovf),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_elem      (w_elem),
        .o_row_last  (o_row_last),
        .o_singular  (o_singular)
    );

    assign o_out_elem_0 = w_elem[0];
    assign o_out_elem_1 = w_elem[1];
    assign o_out_elem_2 = w_elem[2];
    assign o_out_elem_3 = w_elem[3];

    // The lanes run in lock step, so they finish together.
    a_lanes_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done != '0) |-> (w_done == '1))
        else $error("cofactor lanes out of step");

    // A result row is loaded only when the output register can take it.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (!o_out_valid || !i_out_stall))
        else $error("result row loaded over a held beat");

    // No row is taken while the cofactors or the determinant are being formed.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_COF) || (r_state == S_DET)) |-> !w_in_acc)
        else $error("row accepted during cofactor or determinant phase");

    // The last result row returns the sequencer to loading.
    a_last_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && (r_idx == 2'd3)) |=> (r_state == S_LOAD) && o_out_valid && o_row_last)
        else $error("last result row did not end the matrix");

endmodule
`default_nettype wire

@@ hw/rtl/m4i_lane.sv @@
// Cofactor lane: serial multiply-accumulate for one 3x3 minor and a restoring divider.
`default_nettype none
module m4i_lane
    import m4i_pkg::*;
#(
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    localparam int E    = ELEM_WIDTH,
    localparam int CW   = 3 * E + 2,
    localparam int DETW = 4 * E + 2
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_lane_cmd                  i_cmd,
    input  wire logic                       i_sign_base,
    input  wire logic [DIM-1:0][E-1:0]      i_row_a,
    input  wire logic [DIM-1:0][E-1:0]      i_row_b,
    input  wire logic [DIM-1:0][E-1:0]      i_row_c,
    input  wire logic [DETW-1:0]            i_det,
    output t_lane_sts                       o_sts,
    output logic [CW-1:0]                   o_cof0,
    output logic [E:0]                      o_q,
    output logic                            o_neg,
    output logic                            o_ovf
);

    localparam int NW  = CW + 2 * FRAC_BITS;
    localparam int HIW = NW - E;
    localparam int XW  = ((HIW > DETW) ? HIW : DETW) + 1;
    localparam int BW  = $clog2(E);

    typedef enum logic [5:0] {
        L_IDLE   = 6'b000001,
        L_LOAD   = 6'b000010,
        L_STEP   = 6'b000100,
        L_DLOAD  = 6'b001000,
        L_DSTEP  = 6'b010000,
        L_DROUND = 6'b100000
    } t_lstate;

    // Nine multiply-accumulate steps of a 3x3 determinant.
    typedef enum logic [3:0] {
        OP_M_BQ_CR = 4'd0,
        OP_M_BR_CQ = 4'd1,
        OP_A_AP    = 4'd2,
        OP_M_BP_CR = 4'd3,
        OP_M_BR_CP = 4'd4,
        OP_A_AQ    = 4'd5,
        OP_M_BP_CQ = 4'd6,
        OP_M_BQ_CP = 4'd7,
        OP_A_AR    = 4'd8
    } t_op;

    function automatic logic [CW-1:0] sx(input logic [E-1:0] x);
        return {{(CW - E){x[E-1]}}, x};
    endfunction

    t_lstate                r_st;
    t_op                    r_op;
    logic [BW-1:0]          r_bit;
    logic [1:0]             r_col;
    logic [CW-1:0]          r_mc;
    logic [E-1:0]           r_mp;
    logic [CW-1:0]          r_m;
    logic [CW-1:0]          r_acc;
    logic                   r_sub;
    logic                   r_to_acc;
    logic [CW-1:0]          r_cof [DIM];
    logic                   r_done;
    logic [DETW-1:0]        r_rem;
    logic [DETW-1:0]        r_magd;
    logic [E-1:0]           r_nlo;
    logic [E:0]             r_q;
    logic                   r_neg;
    logic                   r_ovf;

    // The three columns left once the cofactor's own column is struck out.
    logic [1:0] w_p, w_q, w_r;
    assign w_p = (r_col == 2'd0) ? 2'd1 : 2'd0;
    assign w_q = (r_col <= 2'd1) ? 2'd2 : 2'd1;
    assign w_r = (r_col == 2'd3) ? 2'd2 : 2'd3;

    // Operand selection for the current step.
    logic [CW-1:0] w_mcand;
    logic [E-1:0]  w_mplier;
    logic          w_to_acc;
    logic          w_clr;
    logic          w_sub;

    always_comb begin
        w_mcand  = '0;
        w_mplier = '0;
        w_to_acc = 1'b0;
        w_clr    = 1'b0;
        w_sub    = 1'b0;
        unique case (r_op)
            OP_M_BQ_CR: begin
                w_mcand = sx(i_row_b[w_q]); w_mplier = i_row_c[w_r]; w_clr = 1'b1;
            end
            OP_M_BR_CQ: begin
                w_mcand = sx(i_row_b[w_r]); w_mplier = i_row_c[w_q]; w_sub = 1'b1;
            end
            OP_A_AP: begin
                w_mcand = r_m; w_mplier = i_row_a[w_p]; w_to_acc = 1'b1; w_clr = 1'b1;
            end
            OP_M_BP_CR: begin
                w_mcand = sx(i_row_b[w_p]); w_mplier = i_row_c[w_r]; w_clr = 1'b1;
            end
            OP_M_BR_CP: begin
                w_mcand = sx(i_row_b[w_r]); w_mplier = i_row_c[w_p]; w_sub = 1'b1;
            end
            OP_A_AQ: begin
                w_mcand = r_m; w_mplier = i_row_a[w_q]; w_to_acc = 1'b1; w_sub = 1'b1;
            end
            OP_M_BP_CQ: begin
                w_mcand = sx(i_row_b[w_p]); w_mplier = i_row_c[w_q]; w_clr = 1'b1;
            end
            OP_M_BQ_CP: begin
                w_mcand = sx(i_row_b[w_q]); w_mplier = i_row_c[w_p]; w_sub = 1'b1;
            end
            OP_A_AR: begin
                w_mcand = r_m; w_mplier = i_row_a[w_r]; w_to_acc = 1'b1;
            end
            default: begin
                w_mcand = '0;
            end
        endcase
    end

    // One bit of the multiplier per cycle; its top bit carries negative weight.
    logic          w_last_bit;
    logic          w_neg_term;
    logic [CW-1:0] w_addend;
    logic [CW-1:0] w_sum;
    logic [CW-1:0] w_cof_val;

    assign w_last_bit = (r_bit == BW'(E - 1));
    assign w_neg_term = r_sub ^ w_last_bit;
    assign w_addend   = r_mp[0] ? (w_neg_term ? ~r_mc : r_mc) : '0;
    assign w_sum      = (r_to_acc ? r_acc : r_m) + w_addend
                        + CW'(r_mp[0] & w_neg_term);
    assign w_cof_val  = (i_sign_base ^ r_col[0]) ? (~w_sum + CW'(1)) : w_sum;

    // Magnitudes and the overflow check at the start of a division.
    logic [CW-1:0]   w_c;
    logic [CW-1:0]   w_magc;
    logic [DETW-1:0] w_magd;
    logic [NW-1:0]   w_n;
    logic [XW-1:0]   w_hi_x;
    logic [XW-1:0]   w_magd_x;

    assign w_c      = r_cof[r_col];
    assign w_magc   = w_c[CW-1] ? (~w_c + CW'(1)) : w_c;
    assign w_magd   = i_det[DETW-1] ? (~i_det + DETW'(1)) : i_det;
    assign w_n      = {w_magc, {(2 * FRAC_BITS){1'b0}}};
    assign w_hi_x   = {{(XW - HIW){1'b0}}, w_n[NW-1:E]};
    assign w_magd_x = {{(XW - DETW){1'b0}}, w_magd};

    // One quotient bit per cycle.
    logic [DETW:0] w_r2;
    logic          w_ge;
    logic [DETW:0] w_r2_sub;
    logic [DETW:0] w_rnd;

    assign w_r2     = {r_rem, r_nlo[E-1]};
    assign w_ge     = (w_r2 >= {1'b0, r_magd});
    assign w_r2_sub = w_r2 - {1'b0, r_magd};
    assign w_rnd    = {r_rem, 1'b0};

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= L_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_st)
                L_IDLE: begin
                    if (i_cmd.start_cof) begin
                        r_st <= L_LOAD;
                    end else if (i_cmd.start_div) begin
                        r_st <= L_DLOAD;
                    end
                end
                L_LOAD: begin
                    r_st <= L_STEP;
                end
                L_STEP: begin
                    if (w_last_bit) begin
                        if (r_op == OP_A_AR) begin
                            r_st   <= L_IDLE;
                            r_done <= 1'b1;
                        end else begin
                            r_st <= L_LOAD;
                        end
                    end
                end
                L_DLOAD: begin
                    r_st <= L_DSTEP;
                end
                L_DSTEP: begin
                    if (w_last_bit) begin
                        r_st <= L_DROUND;
                    end
                end
                L_DROUND: begin
                    r_st   <= L_IDLE;
                    r_done <= 1'b1;
                end
                default: begin
                    r_st <= L_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_st)
            L_IDLE: begin
                r_op  <= OP_M_BQ_CR;
                r_col <= i_cmd.idx;
            end
            L_LOAD: begin
                r_mc     <= w_mcand;
                r_mp     <= w_mplier;
                r_bit    <= '0;
                r_sub    <= w_sub;
                r_to_acc <= w_to_acc;
                if (w_clr) begin
                    if (w_to_acc) begin
                        r_acc <= '0;
                    end else begin
                        r_m <= '0;
                    end
                end
            end
            L_STEP: begin
                if (r_to_acc) begin
                    r_acc <= w_sum;
                end else begin
                    r_m <= w_sum;
                end
                r_mc  <= r_mc << 1;
                r_mp  <= r_mp >> 1;
                r_bit <= r_bit + BW'(1);
                if (w_last_bit) begin
                    if (r_op == OP_A_AR) begin
                        r_cof[r_col] <= w_cof_val;
                    end else begin
                        r_op <= t_op'(r_op + 4'd1);
                    end
                end
            end
            L_DLOAD: begin
                r_ovf  <= (w_hi_x >= w_magd_x);
                r_rem  <= w_hi_x[DETW-1:0];
                r_nlo  <= w_n[E-1:0];
                r_q    <= '0;
                r_bit  <= '0;
                r_neg  <= w_c[CW-1] ^ i_det[DETW-1];
                r_magd <= w_magd;
            end
            L_DSTEP: begin
                r_rem <= w_ge ? w_r2_sub[DETW-1:0] : w_r2[DETW-1:0];
                r_q   <= {r_q[E-1:0], w_ge};
                r_nlo <= r_nlo << 1;
                r_bit <= r_bit + BW'(1);
            end
            L_DROUND: begin
                if (w_rnd >= {1'b0, r_magd}) begin
                    r_q <= r_q + (E + 1)'(1);
                end
            end
            default: begin
                r_op <= OP_M_BQ_CR;
            end
        endcase
    end

    assign o_sts.busy = (r_st != L_IDLE);
    assign o_sts.done = r_done;
    assign o_cof0     = r_cof[0];
    assign o_q        = r_q;
    assign o_neg      = r_neg;
    assign o_ovf      = r_ovf;

endmodule
`default_nettype wire

@@ hw/rtl/m4i_merge.sv @@
// Merging stage: determinant accumulation, sign and saturation, and the output register.
`default_nettype none
module m4i_merge
    import m4i_pkg::*;
#(
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
    localparam int E    = ELEM_WIDTH,
    localparam int CW   = 3 * E + 2,
    localparam int DETW = 4 * E + 2
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_det_start,
    input  wire logic [DIM-1:0][E-1:0]      i_col0,
    input  wire logic [DIM-1:0][CW-1:0]     i_cof0,
    output logic                            o_det_done,
    output logic [DETW-1:0]                 o_det,
    input  wire logic                       i_load,
    input  wire logic                       i_last,
    input  wire logic [DIM-1:0][E:0]        i_q,
    input  wire logic [DIM-1:0]             i_neg,
    input  wire logic [DIM-1:0]             i_ovf,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic [DIM-1:0][E-1:0]           o_elem,
    output logic                            o_row_last,
    output logic                            o_singular
);

    localparam int BW = $clog2(E);

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_LOAD = 3'b010,
        D_STEP = 3'b100
    } t_dstate;

    t_dstate          r_st;
    logic [1:0]       r_j;
    logic [BW-1:0]    r_bit;
    logic [DETW-1:0]  r_mc;
    logic [E-1:0]     r_mp;
    logic [DETW-1:0]  r_det;
    logic             r_done;
    logic             r_valid;
    logic [DIM-1:0][E-1:0] r_elem;
    logic             r_last;
    logic             r_sing;

    // Determinant by expansion down the first column, one multiplier bit a cycle.
    logic            w_last_bit;
    logic [DETW-1:0] w_addend;
    logic [DETW-1:0] w_sum;
    logic [CW-1:0]   w_cof;

    assign w_last_bit = (r_bit == BW'(E - 1));
    assign w_addend   = r_mp[0] ? (w_last_bit ? ~r_mc : r_mc) : '0;
    assign w_sum      = r_det + w_addend + DETW'(r_mp[0] & w_last_bit);
    assign w_cof      = i_cof0[r_j];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= D_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_st)
                D_IDLE: begin
                    if (i_det_start) begin
                        r_st <= D_LOAD;
                    end
                end
                D_LOAD: begin
                    r_st <= D_STEP;
                end
                D_STEP: begin
                    if (w_last_bit) begin
                        if (r_j == 2'd3) begin
                            r_st   <= D_IDLE;
                            r_done <= 1'b1;
                        end else begin
                            r_st <= D_LOAD;
                        end
                    end
                end
                default: begin
                    r_st <= D_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            D_IDLE: begin
                r_j <= 2'd0;
                if (i_det_start) begin
                    r_det <= '0;
                end
            end
            D_LOAD: begin
                r_mc  <= {{(DETW - CW){w_cof[CW-1]}}, w_cof};
                r_mp  <= i_col0[r_j];
                r_bit <= '0;
            end
            D_STEP: begin
                r_det <= w_sum;
                r_mc  <= r_mc << 1;
                r_mp  <= r_mp >> 1;
                r_bit <= r_bit + BW'(1);
                if (w_last_bit) begin
                    r_j <= r_j + 2'd1;
                end
            end
            default: begin
                r_j <= 2'd0;
            end
        endcase
    end

    // Sign, saturation and the zero case for one result row.
    logic                  w_sing;
    logic [DIM-1:0][E-1:0] w_elem;

    assign w_sing = (r_det == '0);

    always_comb begin
        logic [E:0] lim;
        logic [E:0] v;
        logic [E:0] s;
        for (int k = 0; k < DIM; k++) begin
            lim = ((E + 1)'(1) << (E - 1)) - (E + 1)'(!i_neg[k]);
            v   = (i_ovf[k] || (i_q[k] > lim)) ? lim : i_q[k];
            s   = i_neg[k] ? (~v + (E + 1)'(1)) : v;
            w_elem[k] = w_sing ? '0 : s[E-1:0];
        end
    end

    // Output register; a held beat stays until taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_elem <= w_elem;
            r_last <= i_last;
            r_sing <= w_sing;
        end
    end

    assign o_det_done = r_done;
    assign o_det      = r_det;
    assign o_valid    = r_valid;
    assign o_elem     = r_elem;
    assign o_row_last = r_last;
    assign o_singular = r_sing;

endmodule
`default_nettype wire
